### sv/qrm_pkg.sv
// qrm_pkg: widths, types and helpers for the quaternion renorm to matrix block
// used by qrm_renorm, qrm_matrix and quaternion_renorm_to_matrix_core
// no dependencies
package qrm_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int Q_W        = 15;
  localparam int N_W        = 17;
  localparam int C_W        = 16;
  localparam int ROW_W      = 2;

  localparam int SQ_W       = 2 * Q_W;
  localparam int SSQ_W      = SQ_W + 2;
  localparam int S_W        = SSQ_W - FRAC_BITS;
  localparam int P_W        = S_W + Q_W;
  localparam int PS_W       = P_W - FRAC_BITS;
  localparam int PROD_SHIFT = FRAC_BITS - 1;
  localparam int NP_W       = 2 * N_W;
  localparam int R_W        = NP_W + 1 - PROD_SHIFT;
  localparam int M_W        = R_W + 2;

  localparam logic [ROW_W-1:0] ROW_0 = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_1 = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_2 = ROW_W'(2);

  typedef logic signed [Q_W-1:0] quat_t;
  typedef logic signed [N_W-1:0] norm_t;
  typedef logic signed [C_W-1:0] col_t;
  typedef logic signed [R_W-1:0] prod_t;

  typedef struct packed {
    logic  valid;
    norm_t x;
    norm_t y;
    norm_t z;
    norm_t w;
  } norm_req_t;

  function automatic norm_t sat_norm(input logic signed [PS_W-1:0] v);
    norm_t r;
    if (v[PS_W-1] && !(&v[PS_W-1:N_W-1])) begin
      r = {1'b1, {(N_W-1){1'b0}}};
    end else if (!v[PS_W-1] && (|v[PS_W-1:N_W-1])) begin
      r = {1'b0, {(N_W-1){1'b1}}};
    end else begin
      r = v[N_W-1:0];
    end
    return r;
  endfunction

  function automatic col_t sat_col(input logic signed [M_W-1:0] v);
    col_t r;
    if (v[M_W-1] && !(&v[M_W-1:C_W-1])) begin
      r = {1'b1, {(C_W-1){1'b0}}};
    end else if (!v[M_W-1] && (|v[M_W-1:C_W-1])) begin
      r = {1'b0, {(C_W-1){1'b1}}};
    end else begin
      r = v[C_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/quaternion_renorm_to_matrix_core.sv
// quaternion_renorm_to_matrix_core: top level of the quaternion renorm to
// rotation matrix block; depends on qrm_pkg, qrm_renorm, qrm_matrix
//
// request channel: quat_x/y/z/w (signed 2.12) are taken at a rising edge
// with start high and busy low. busy goes high after each accepted request,
// and no new request is taken until it falls again;
// the single result channel carries three rows per request, which is
// what sets that spacing.
// result channel: done marks one row for exactly one cycle; rows 0, 1, 2
// come in consecutive cycles, last_row marks row 2, and norm_x/y/z/w carry
// the renormalized quaternion on every row.
// pipeline: the work runs through six register stages (squares, scale,
// scaled components, saturation, products, matrix), row 0 showing from
// the last; every stage moves each cycle, so requests accepted as soon as
// busy allows overlap in flight.
// the receiver cannot stall; nothing is held back on the result side.
// reset (rst, synchronous) clears all valid bits, the row serializer and
// busy; no result appears until a new request has gone through.
module quaternion_renorm_to_matrix_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  qrm_pkg::quat_t            quat_x,
  input  qrm_pkg::quat_t            quat_y,
  input  qrm_pkg::quat_t            quat_z,
  input  qrm_pkg::quat_t            quat_w,
  output logic                      done,
  output logic [qrm_pkg::ROW_W-1:0] row_index,
  output qrm_pkg::col_t             col_zero,
  output qrm_pkg::col_t             col_one,
  output qrm_pkg::col_t             col_two,
  output qrm_pkg::norm_t            norm_x,
  output qrm_pkg::norm_t            norm_y,
  output qrm_pkg::norm_t            norm_z,
  output qrm_pkg::norm_t            norm_w,
  output logic                      last_row
);
  import qrm_pkg::*;

  localparam logic [1:0] HOLD_CYCLES = 2'd2;

  logic      accept;
  logic [1:0] hold;
  logic [1:0] hold_next;
  norm_req_t norm_req;

  assign accept = start && !busy;
  assign busy   = (hold != 2'd0);

  always_comb begin
    if (accept) begin
      hold_next = HOLD_CYCLES;
    end else if (hold != 2'd0) begin
      hold_next = hold - 2'd1;
    end else begin
      hold_next = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 2'd0;
    end else begin
      hold <= hold_next;
    end
  end

  qrm_renorm u_renorm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .quat_w   (quat_w),
    .norm_out (norm_req)
  );

  qrm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .norm_in   (norm_req),
    .done      (done),
    .row_index (row_index),
    .col_zero  (col_zero),
    .col_one   (col_one),
    .col_two   (col_two),
    .norm_x    (norm_x),
    .norm_y    (norm_y),
    .norm_z    (norm_z),
    .norm_w    (norm_w),
    .last_row  (last_row)
  );

endmodule

### sv/qrm_renorm.sv
// qrm_renorm: four-stage renormalization pipeline (squares, scale, scaled
// components, saturation); depends on qrm_pkg
module qrm_renorm (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  qrm_pkg::quat_t    quat_x,
  input  qrm_pkg::quat_t    quat_y,
  input  qrm_pkg::quat_t    quat_z,
  input  qrm_pkg::quat_t    quat_w,
  output qrm_pkg::norm_req_t norm_out
);
  import qrm_pkg::*;

  localparam logic signed [SSQ_W-1:0] SCALE_BASE = SSQ_W'(3 << (FRAC_BITS - 1));
  localparam logic signed [SSQ_W-1:0] TINY_LIMIT = SSQ_W'(1 << (2 * FRAC_BITS - 14));
  localparam norm_t ONE_N = N_W'(1 << FRAC_BITS);

  quat_t                   q_in [4];
  logic signed [SQ_W-1:0]  sq_c [4];

  logic                    v1;
  quat_t                   q1 [4];
  logic signed [SQ_W-1:0]  sq1 [4];

  logic signed [SSQ_W-1:0] ssq_c;
  logic signed [SSQ_W-1:0] ssq_sh;
  logic signed [SSQ_W-1:0] s_wide;

  logic                    v2;
  logic                    tiny2;
  quat_t                   q2 [4];
  logic signed [S_W-1:0]   s2;

  logic signed [P_W-1:0]   p_c [4];

  logic                    v3;
  logic                    tiny3;
  logic signed [P_W-1:0]   p3 [4];

  norm_t                   n_c [4];
  norm_req_t               n4;

  assign q_in[0] = quat_x;
  assign q_in[1] = quat_y;
  assign q_in[2] = quat_z;
  assign q_in[3] = quat_w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_c[i] = q_in[i] * q_in[i];
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    for (int i = 0; i < 4; i++) begin
      q1[i]  <= q_in[i];
      sq1[i] <= sq_c[i];
    end
  end

  always_comb begin
    ssq_c  = SSQ_W'(sq1[0]) + SSQ_W'(sq1[1]) + SSQ_W'(sq1[2]) + SSQ_W'(sq1[3]);
    ssq_sh = ssq_c >>> (FRAC_BITS + 1);
    s_wide = SCALE_BASE - ssq_sh;
  end

  // stage 2: sum of squares and newton scale
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    tiny2 <= (ssq_c < TINY_LIMIT);
    s2    <= s_wide[S_W-1:0];
    for (int i = 0; i < 4; i++) begin
      q2[i] <= q1[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      p_c[i] = s2 * q2[i];
    end
  end

  // stage 3: scaled components
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    tiny3 <= tiny2;
    for (int i = 0; i < 4; i++) begin
      p3[i] <= p_c[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n_c[i] = sat_norm(PS_W'(p3[i] >>> FRAC_BITS));
    end
  end

  // stage 4: floor shift, saturation, identity for a tiny quaternion
  always_ff @(posedge clk) begin
    if (rst) begin
      n4.valid <= 1'b0;
    end else begin
      n4.valid <= v3;
    end
    if (tiny3) begin
      n4.x <= '0;
      n4.y <= '0;
      n4.z <= '0;
      n4.w <= ONE_N;
    end else begin
      n4.x <= n_c[0];
      n4.y <= n_c[1];
      n4.z <= n_c[2];
      n4.w <= n_c[3];
    end
  end

  assign norm_out = n4;

endmodule

### sv/qrm_matrix.sv
// qrm_matrix: rounded pairwise products, matrix assembly with saturation and
// the row serializer; depends on qrm_pkg
module qrm_matrix (
  input  logic                           clk,
  input  logic                           rst,
  input  qrm_pkg::norm_req_t             norm_in,
  output logic                           done,
  output logic [qrm_pkg::ROW_W-1:0]      row_index,
  output qrm_pkg::col_t                  col_zero,
  output qrm_pkg::col_t                  col_one,
  output qrm_pkg::col_t                  col_two,
  output qrm_pkg::norm_t                 norm_x,
  output qrm_pkg::norm_t                 norm_y,
  output qrm_pkg::norm_t                 norm_z,
  output qrm_pkg::norm_t                 norm_w,
  output logic                           last_row
);
  import qrm_pkg::*;

  localparam logic signed [NP_W:0]  ROUND = (NP_W+1)'(1 << (PROD_SHIFT - 1));
  localparam logic signed [M_W-1:0] ONE_M = M_W'(1 << FRAC_BITS);

  function automatic prod_t rprod(input norm_t a, input norm_t b);
    logic signed [NP_W:0] t;
    logic signed [NP_W:0] sh;
    t  = a * b;
    t  = t + ROUND;
    sh = t >>> PROD_SHIFT;
    return sh[R_W-1:0];
  endfunction

  logic      v5;
  prod_t     xx, yy, zz, xy, xz, yz, xw, yw, zw;
  norm_t     n5 [4];

  logic signed [M_W-1:0] m_c [9];

  col_t      mat [9];
  norm_t     n6 [4];
  logic      active;
  logic [ROW_W-1:0] row;

  // stage 5: nine rounded products
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= norm_in.valid;
    end
    xx <= rprod(norm_in.x, norm_in.x);
    yy <= rprod(norm_in.y, norm_in.y);
    zz <= rprod(norm_in.z, norm_in.z);
    xy <= rprod(norm_in.x, norm_in.y);
    xz <= rprod(norm_in.x, norm_in.z);
    yz <= rprod(norm_in.y, norm_in.z);
    xw <= rprod(norm_in.x, norm_in.w);
    yw <= rprod(norm_in.y, norm_in.w);
    zw <= rprod(norm_in.z, norm_in.w);
    n5[0] <= norm_in.x;
    n5[1] <= norm_in.y;
    n5[2] <= norm_in.z;
    n5[3] <= norm_in.w;
  end

  always_comb begin
    m_c[0] = ONE_M - (M_W'(yy) + M_W'(zz));
    m_c[1] = M_W'(xy) - M_W'(zw);
    m_c[2] = M_W'(xz) + M_W'(yw);
    m_c[3] = M_W'(xy) + M_W'(zw);
    m_c[4] = ONE_M - (M_W'(xx) + M_W'(zz));
    m_c[5] = M_W'(yz) - M_W'(xw);
    m_c[6] = M_W'(xz) - M_W'(yw);
    m_c[7] = M_W'(yz) + M_W'(xw);
    m_c[8] = ONE_M - (M_W'(xx) + M_W'(yy));
  end

  // stage 6: matrix registers and row serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= ROW_0;
    end else if (v5) begin
      active <= 1'b1;
      row    <= ROW_0;
    end else if (active) begin
      if (row == ROW_2) begin
        active <= 1'b0;
      end else begin
        row <= row + ROW_W'(1);
      end
    end
    if (v5) begin
      for (int i = 0; i < 9; i++) begin
        mat[i] <= sat_col(m_c[i]);
      end
      for (int i = 0; i < 4; i++) begin
        n6[i] <= n5[i];
      end
    end
  end

  always_comb begin
    case (row)
      ROW_0: begin
        col_zero = mat[0];
        col_one  = mat[1];
        col_two  = mat[2];
      end
      ROW_1: begin
        col_zero = mat[3];
        col_one  = mat[4];
        col_two  = mat[5];
      end
      default: begin
        col_zero = mat[6];
        col_one  = mat[7];
        col_two  = mat[8];
      end
    endcase
  end

  assign done      = active;
  assign row_index = row;
  assign last_row  = (row == ROW_2);
  assign norm_x    = n6[0];
  assign norm_y    = n6[1];
  assign norm_z    = n6[2];
  assign norm_w    = n6[3];

endmodule

### sv/qrm_checker.sv
// qrm_checker: port-level assertions for quaternion_renorm_to_matrix_core
// and the bind that attaches them; depends on qrm_pkg
module qrm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic [qrm_pkg::ROW_W-1:0] row_index,
  input qrm_pkg::norm_t            norm_x,
  input qrm_pkg::norm_t            norm_y,
  input qrm_pkg::norm_t            norm_z,
  input qrm_pkg::norm_t            norm_w,
  input logic                      last_row
);
  import qrm_pkg::*;

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 (done && row_index == ROW_0))
    else $error("row 0 missing six cycles after request");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (done && row_index == ROW_0) |=> (done && row_index == ROW_1))
    else $error("row 1 does not follow row 0");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (done && row_index == ROW_1) |=> (done && row_index == ROW_2 && last_row))
    else $error("row 2 with last_row does not follow row 1");

  a_norm_stable: assert property (@(posedge clk) disable iff (rst)
    (done && row_index != ROW_2) |=>
      ($stable(norm_x) && $stable(norm_y) && $stable(norm_z) && $stable(norm_w)))
    else $error("renormalized quaternion changed within one request");

endmodule

bind quaternion_renorm_to_matrix_core qrm_checker u_qrm_checker (.*);
